@@ hdl/lfupr_pkg.sv @@
// package for the lfu page replacement block: default sizes, fixed field widths
// and the sequencer state type; no dependencies
package lfupr_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // fixed widths of the result fields and counters
   localparam int TS_W       = 32;
   localparam int FAULT_W    = 32;
   localparam int SLOT_OUT_W = 4;
   localparam int EVPAGE_W   = 16;

   // frame limit register
   localparam int CSR_W = 5;
   localparam logic [CSR_W-1:0] CSR_LIMIT_RESET = 5'd16;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } lfupr_state_type;

endpackage

@@ hdl/lfupr_frame_mem.sv @@
// frame table memory: one word per frame holding page, use count and timestamp
// one write port, one read port with registered read data; uses lfupr_pkg
module lfupr_frame_mem
   import lfupr_pkg::*;
#(
   parameter int DEPTH  = MAX_FRAMES_DEF,
   parameter int WIDTH  = PAGE_BITS_DEF + COUNT_BITS_DEF + TS_W,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lfupr_ctrl.sv @@
// sequencer: scans the frame table for a hit and the eviction candidate,
// then writes back the chosen frame and registers the result; uses lfupr_pkg
module lfupr_ctrl
   import lfupr_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int ADDR_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   parameter int ENTRY_W    = PAGE_BITS + COUNT_BITS + TS_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_BITS-1:0]  req_page,
   input  logic [CSR_W-1:0]      frame_limit,
   output logic                  mem_wr_en,
   output logic [ADDR_W-1:0]     mem_wr_addr,
   output logic [ENTRY_W-1:0]    mem_wr_data,
   output logic [ADDR_W-1:0]     mem_rd_addr,
   input  logic [ENTRY_W-1:0]    mem_rd_data,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_frame_slot,
   output logic                  rsp_evicted,
   output logic [EVPAGE_W-1:0]   rsp_evicted_page,
   output logic [FAULT_W-1:0]    rsp_fault_total
);

   localparam int LIM_W = $clog2(MAX_FRAMES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   lfupr_state_type state_ff, state_in;

   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [LIM_W-1:0]      lim_ff, lim_in;
   logic [LIM_W-1:0]      fill_ff, fill_in;
   logic [TS_W-1:0]       req_idx_ff, req_idx_in;
   logic [FAULT_W-1:0]    fault_ff, fault_in;
   logic [ADDR_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                  found_ff, found_in;
   logic [ADDR_W-1:0]     hit_slot_ff, hit_slot_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [ADDR_W-1:0]     best_slot_ff, best_slot_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [TS_W-1:0]       best_age_ff, best_age_in;
   logic [PAGE_BITS-1:0]  best_page_ff, best_page_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [EVPAGE_W-1:0]   rsp_evpage_ff, rsp_evpage_in;

   // fields of the word read back from the frame table
   logic [PAGE_BITS-1:0]  rd_page;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic [TS_W-1:0]       rd_age;
   logic [LIM_W-1:0]      lim_eff;
   logic [ADDR_W-1:0]     slot;
   logic [COUNT_BITS-1:0] new_cnt;

   assign {rd_page, rd_cnt, rd_age} = mem_rd_data;

   // clamp the frame limit to 1 .. MAX_FRAMES
   always_comb begin
      if (frame_limit == '0) begin
         lim_eff = LIM_W'(1);
      end else if (32'(frame_limit) > MAX_FRAMES) begin
         lim_eff = LIM_W'(MAX_FRAMES);
      end else begin
         lim_eff = LIM_W'(frame_limit);
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         req_idx_ff   <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         req_idx_ff   <= req_idx_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload registers
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      lim_ff        <= lim_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_cnt_ff    <= hit_cnt_in;
      best_slot_ff  <= best_slot_in;
      best_cnt_ff   <= best_cnt_in;
      best_age_ff   <= best_age_in;
      best_page_ff  <= best_page_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_evpage_ff <= rsp_evpage_in;
   end

   // next state, scan and write back
   always_comb begin
      state_in      = state_ff;
      page_in       = page_ff;
      lim_in        = lim_ff;
      fill_in       = fill_ff;
      req_idx_in    = req_idx_ff;
      fault_in      = fault_ff;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_cnt_in    = hit_cnt_ff;
      best_slot_in  = best_slot_ff;
      best_cnt_in   = best_cnt_ff;
      best_age_in   = best_age_ff;
      best_page_in  = best_page_ff;
      rsp_valid_in  = 1'b0;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_evpage_in = rsp_evpage_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_addr   = '0;
      slot          = '0;
      new_cnt       = '0;

      case (state_ff)
         ST_IDLE: begin
            // read of frame 0 goes out with the accepted beat
            mem_rd_addr = '0;
            if (start) begin
               page_in    = req_page;
               lim_in     = lim_eff;
               cmp_idx_in = '0;
               found_in   = 1'b0;
               state_in   = (fill_ff == '0) ? ST_DECIDE : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // data on the read port belongs to frame cmp_idx_ff
            mem_rd_addr = cmp_idx_ff + ADDR_W'(1);
            if (rd_page == page_ff) begin
               found_in    = 1'b1;
               hit_slot_in = cmp_idx_ff;
               hit_cnt_in  = rd_cnt;
               state_in    = ST_DECIDE;
            end else begin
               // eviction candidate: lowest count, then oldest, then lowest index
               if (32'(cmp_idx_ff) < 32'(lim_ff)) begin
                  if (cmp_idx_ff == '0 || rd_cnt < best_cnt_ff ||
                      (rd_cnt == best_cnt_ff && rd_age < best_age_ff)) begin
                     best_slot_in = cmp_idx_ff;
                     best_cnt_in  = rd_cnt;
                     best_age_in  = rd_age;
                     best_page_in = rd_page;
                  end
               end
               if (32'(cmp_idx_ff) + 1 == 32'(fill_ff)) begin
                  state_in = ST_DECIDE;
               end else begin
                  cmp_idx_in = cmp_idx_ff + ADDR_W'(1);
               end
            end
         end

         ST_DECIDE: begin
            rsp_ev_in     = 1'b0;
            rsp_evpage_in = '0;
            if (found_ff) begin
               slot    = hit_slot_ff;
               new_cnt = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff
                                                   : hit_cnt_ff + COUNT_BITS'(1);
            end else begin
               new_cnt = COUNT_BITS'(1);
               if (fault_ff != '1) begin
                  fault_in = fault_ff + FAULT_W'(1);
               end
               if (fill_ff < lim_ff) begin
                  slot    = ADDR_W'(fill_ff);
                  fill_in = fill_ff + LIM_W'(1);
               end else begin
                  slot          = best_slot_ff;
                  rsp_ev_in     = 1'b1;
                  rsp_evpage_in = EVPAGE_W'(best_page_ff);
               end
            end
            mem_wr_en    = 1'b1;
            mem_wr_addr  = slot;
            mem_wr_data  = {page_ff, new_cnt, req_idx_ff};
            req_idx_in   = req_idx_ff + TS_W'(1);
            rsp_valid_in = 1'b1;
            rsp_hit_in   = found_ff;
            rsp_slot_in  = SLOT_OUT_W'(32'(slot));
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_slot   = rsp_slot_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_evicted_page = rsp_evpage_ff;
   assign rsp_fault_total  = fault_ff;

endmodule

@@ hdl/lfu_page_replacement.sv @@
// top level of the lfu page replacement block: frame limit register, sequencer
// and frame table memory; uses lfupr_pkg, lfupr_ctrl, lfupr_frame_mem
//
//  channel   ports                               handshake
//  request   start, busy, req_page               taken when start and !busy
//  result    rsp_valid, rsp_hit .. rsp_fault_total  one-cycle strobe, no backpressure
//  config    csr_valid, csr_ready, csr_data      written when valid and ready
//
// a request goes from accept through a scan of the filled frames to the write
// back and its result strobe; the scan reads one frame per cycle through the
// single read port of the frame table and stops early when a hit is found.
// busy drops in the strobe cycle, so the next beat can be taken then.
// synchronous reset clears control state; the frame table needs no clearing
// pass since only filled frames are ever read.
module lfu_page_replacement
   import lfupr_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_BITS-1:0]  req_page,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [SLOT_OUT_W-1:0] rsp_frame_slot,
   output logic                  rsp_evicted,
   output logic [EVPAGE_W-1:0]   rsp_evicted_page,
   output logic [FAULT_W-1:0]    rsp_fault_total,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_W-1:0]      csr_data
);

   localparam int ADDR_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int ENTRY_W = PAGE_BITS + COUNT_BITS + TS_W;

   logic [CSR_W-1:0]   csr_limit_ff, csr_limit_in;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   // frame limit register, always ready for a beat
   assign csr_ready    = 1'b1;
   assign csr_limit_in = (csr_valid && csr_ready) ? csr_data : csr_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_limit_ff <= CSR_LIMIT_RESET;
      end else begin
         csr_limit_ff <= csr_limit_in;
      end
   end

   // sequencer
   lfupr_ctrl #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .ADDR_W     (ADDR_W),
      .ENTRY_W    (ENTRY_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page         (req_page),
      .frame_limit      (csr_limit_ff),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_frame_slot   (rsp_frame_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total)
   );

   // frame table
   lfupr_frame_mem #(
      .DEPTH  (MAX_FRAMES),
      .WIDTH  (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

`ifndef SYNTH
   // an accepted beat keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // one strobe per request, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // a hit never evicts
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted)
      else $error("eviction reported on a hit");

   // evicted page reads zero when nothing was evicted
   a_evpage_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without eviction");
`endif

endmodule

@@ sim/tb_lfu_page_replacement.sv @@
`timescale 1ns / 100ps
// testbench for lfu_page_replacement (needs lfupr_pkg): a directed table, then phases
// of random pages; each result is checked against its typed row or the lfu/lru model
module tb_lfu_page_replacement;
   import lfupr_pkg::*;

   localparam int NFRAMES         = MAX_FRAMES_DEF;
   localparam int PAGE_W          = PAGE_BITS_DEF;
   localparam int COUNT_W         = COUNT_BITS_DEF;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int NPHASES         = 10;
   localparam int IDLE_PCT        = 34;
   localparam int MAX_SHOWN       = 10;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evicted;
      logic [EVPAGE_W-1:0]   ev_page;
      logic [FAULT_W-1:0]    faults;
   } access_result_type;

   typedef enum logic {
      ROW_PAGE,
      ROW_LIMIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [15:0]       value;
      logic              typed;
      access_result_type want;
   } dir_row_type;

   localparam access_result_type NO_RESULT = '0;

   // dut ports, the inputs all known from time zero
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic [PAGE_W-1:0]     req_page  = '0;
   logic                  csr_valid = 1'b0;
   logic [CSR_W-1:0]      csr_data  = '0;
   logic                  busy;
   logic                  csr_ready;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [SLOT_OUT_W-1:0] rsp_frame_slot;
   logic                  rsp_evicted;
   logic [EVPAGE_W-1:0]   rsp_evicted_page;
   logic [FAULT_W-1:0]    rsp_fault_total;

   // frame table model
   logic [PAGE_W-1:0]  res_page  [NFRAMES];
   logic [COUNT_W-1:0] res_count [NFRAMES] = '{default: '0};
   logic [TS_W-1:0]    res_stamp [NFRAMES] = '{default: '0};
   int                 res_filled  = 0;
   logic [TS_W-1:0]    req_count   = '0;
   logic [FAULT_W-1:0] fault_sum   = '0;
   logic [CSR_W-1:0]   frame_limit = CSR_LIMIT_RESET;

   access_result_type pending_results [$];
   access_result_type want_beat, got_beat;
   int                err_cnt = 0;
   bit                idle_on = 1'b1;

   // directed part: typed expectations only where they are obvious
   dir_row_type dir_tab [25] = '{
      '{ROW_PAGE,  16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0000, 32'd1}},
      '{ROW_PAGE,  16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0000, 32'd2}},
      '{ROW_PAGE,  16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0000, 32'd2}},
      // limit zero acts as one; frame 1 stays visible to hits
      '{ROW_LIMIT, 16'd0,    1'b0, NO_RESULT},
      '{ROW_PAGE,  16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0000, 32'd2}},
      '{ROW_PAGE,  16'h1234, 1'b1, '{1'b0, 4'd0, 1'b1, 16'h0000, 32'd3}},
      // oversized limit acts as the full table, free frames fill again
      '{ROW_LIMIT, 16'd31,   1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h5555, 1'b1, '{1'b0, 4'd2, 1'b0, 16'h0000, 32'd4}},
      '{ROW_PAGE,  16'hAAAA, 1'b1, '{1'b0, 4'd3, 1'b0, 16'h0000, 32'd5}},
      '{ROW_PAGE,  16'h8000, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h4001, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h2002, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h1004, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0808, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0410, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0220, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0140, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'hC0C0, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h3F3F, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'hFFFE, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0001, 1'b0, NO_RESULT},
      // table full: count tie broken by oldest use
      '{ROW_PAGE,  16'h6666, 1'b0, NO_RESULT},
      // limit lowered with all frames filled
      '{ROW_LIMIT, 16'd4,    1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h0220, 1'b0, NO_RESULT},
      '{ROW_PAGE,  16'h7777, 1'b0, NO_RESULT}
   };

   logic [CSR_W-1:0] phase_limit [NPHASES] = '{
      5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd20, 5'd12, 5'd31, 5'd2, 5'd16
   };

   lfu_page_replacement i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_frame_slot   (rsp_frame_slot),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic flag_error(input string msg);
      err_cnt++;
      if (err_cnt <= MAX_SHOWN) $display("%s", msg);
   endtask

   // register value zero means one frame, above the table means the whole table
   function automatic int eff_limit(input logic [CSR_W-1:0] v);
      if (v == 0) return 1;
      if (v > NFRAMES) return NFRAMES;
      return int'(v);
   endfunction

   // one request against the frame table: hit lookup, fill or lfu/lru eviction
   function automatic access_result_type predict_access(input logic [PAGE_W-1:0] pg);
      access_result_type r;
      int                lim;
      int                slot;
      bit                found;
      r     = NO_RESULT;
      lim   = eff_limit(frame_limit);
      slot  = 0;
      found = 1'b0;
      // hits are looked for in every filled frame, whatever the limit
      for (int j = 0; j < res_filled; j++) begin
         if (!found && res_page[j] == pg) begin
            slot  = j;
            found = 1'b1;
         end
      end
      if (found) begin
         if (res_count[slot] != '1) res_count[slot]++;
         res_stamp[slot] = req_count;
      end else begin
         if (fault_sum != '1) fault_sum++;
         if (res_filled < lim) begin
            slot = res_filled;
            res_filled++;
         end else begin
            // lowest count, then oldest stamp, then lowest index
            for (int j = 1; j < lim; j++) begin
               if (res_count[j] < res_count[slot] ||
                   (res_count[j] == res_count[slot] && res_stamp[j] < res_stamp[slot]))
                  slot = j;
            end
            r.evicted = 1'b1;
            r.ev_page = res_page[slot];
         end
         res_page[slot]  = pg;
         res_count[slot] = COUNT_W'(1);
         res_stamp[slot] = req_count;
      end
      req_count++;
      r.hit    = found;
      r.slot   = SLOT_OUT_W'(slot);
      r.faults = fault_sum;
      return r;
   endfunction

   // mostly a small skewed pool around base so counts spread; some wide noise
   function automatic logic [PAGE_W-1:0] pick_page(input logic [PAGE_W-1:0] base,
                                                   input int span);
      int a, b;
      if ($urandom_range(99) < 10) return PAGE_W'($urandom);
      a = $urandom_range(span, 0);
      b = $urandom_range(span, 0);
      return base ^ PAGE_W'((a < b) ? a : b);
   endfunction

   // request beat: random gaps, then hold start until taken
   task automatic send_page(input logic [PAGE_W-1:0] pg, input logic typed,
                            input access_result_type typed_want);
      access_result_type r;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_page <= pg;
      do @(posedge clock); while (busy);
      r = predict_access(pg);
      pending_results.push_back(typed ? typed_want : r);
   endtask

   // limit write, only once every result is back
   task automatic write_limit(input logic [CSR_W-1:0] v);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      frame_limit = v;
      csr_valid <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_beat = '{rsp_hit, rsp_frame_slot, rsp_evicted, rsp_evicted_page,
                      rsp_fault_total};
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected result beat at %0t: hit %0d slot %0d",
                                 $time, rsp_hit, rsp_frame_slot));
         end else begin
            want_beat = pending_results.pop_front();
            if (got_beat !== want_beat)
               flag_error($sformatf({"mismatch at %0t: expected hit %0d slot %0d ev %0d ",
                                     "evpage %h faults %0d, got hit %0d slot %0d ev %0d ",
                                     "evpage %h faults %0d"}, $time,
                                    want_beat.hit, want_beat.slot, want_beat.evicted,
                                    want_beat.ev_page, want_beat.faults,
                                    got_beat.hit, got_beat.slot, got_beat.evicted,
                                    got_beat.ev_page, got_beat.faults));
         end
      end
   end

   // stimulus
   initial begin
      logic [PAGE_W-1:0] base;
      int                span;
      base = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_LIMIT)
            write_limit(dir_tab[i].value[CSR_W-1:0]);
         else
            send_page(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
      end

      // random phases, each under its own limit; one phase runs without gaps
      for (int p = 0; p < NPHASES; p++) begin
         write_limit(phase_limit[p]);
         if (p % 2 == 0) base = PAGE_W'($urandom);
         idle_on = (p != 4);
         span    = 2 * eff_limit(phase_limit[p]) + 1;
         repeat (ITEMS_PER_PHASE) send_page(pick_page(base, span), 1'b0, NO_RESULT);
      end
      start <= 1'b0;

      // drain
      for (int w = 0; w < 400 && pending_results.size() != 0; w++) @(posedge clock);
      repeat (NFRAMES + 4) @(posedge clock);
      if (pending_results.size() != 0)
         flag_error($sformatf("%0d expected results never arrived",
                              pending_results.size()));
      if (err_cnt == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/lfupr_pkg.sv
hdl/lfupr_frame_mem.sv
hdl/lfupr_ctrl.sv
hdl/lfu_page_replacement.sv
sim/tb_lfu_page_replacement.sv
